// File: rtl/core/rvref_pkg.sv
// Shared types, widths, register codes and the LFSR step for the
// random victim selector with recent-eviction filter. No dependencies.
`timescale 1ns / 1ps

package rvref_pkg;

    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int SLOT_BITS_DEF     = 16;

    localparam int TOTAL_SLOTS_W = 17;
    localparam int HIST_LEN_W    = 6;
    localparam int MAX_RETRY_W   = 8;
    localparam int LFSR_W        = 32;
    localparam int TAG_W         = 8;
    localparam int RETRY_W       = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [LFSR_W-1:0]        LFSR_TAPS       = 32'h8020_0003;
    localparam logic [TOTAL_SLOTS_W-1:0] TOTAL_SLOTS_RST = 17'd65536;
    localparam logic [HIST_LEN_W-1:0]    HIST_LEN_RST    = 6'd32;
    localparam logic [MAX_RETRY_W-1:0]   MAX_RETRY_RST   = 8'd5;
    localparam logic [LFSR_W-1:0]        LFSR_SEED_RST   = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_SLOTS = 2'd0,
        CFG_HISTORY_LEN = 2'd1,
        CFG_RETRY_LIMIT = 2'd2,
        CFG_LFSR_SEED   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SRCH = 5'b00100,
        S_PUSH = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// File: rtl/core/rvref_ring_mem.sv
// Recent-victim ring storage: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rvref_ring_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rvref_mod_unit.sv
// Bit-serial restoring remainder unit: 32-bit dividend modulo a slot count.
// One quotient bit per cycle; depends on rvref_pkg.
`timescale 1ns / 1ps

module rvref_mod_unit #(
    parameter int SLOT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rvref_pkg::LFSR_W-1:0] i_dividend,
    input  logic [SLOT_BITS:0]          i_divisor,
    output logic                        o_done,
    output logic [SLOT_BITS-1:0]        o_rem
);

    localparam int CNT_W = $clog2(rvref_pkg::LFSR_W);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [rvref_pkg::LFSR_W-1:0] r_quo, n_quo;
    logic [SLOT_BITS-1:0]         r_rem, n_rem;
    logic [SLOT_BITS:0]           w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        w_trial = {r_rem, r_quo[rvref_pkg::LFSR_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[rvref_pkg::LFSR_W-2:0], 1'b0};
            if (w_trial >= i_divisor) begin
                n_rem = SLOT_BITS'(w_trial - i_divisor);
            end else begin
                n_rem = SLOT_BITS'(w_trial);
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(rvref_pkg::LFSR_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/core/random_victim_recent_evict_filter_unit.sv
// Fill beats: accepted in S_IDLE, then S_OUT loads the output register. Evictions:
// each pick runs the serial remainder (S_DIV), then opens the scan and compares
// ring entries in turn (S_SRCH), for up to retry limit + 1 picks; then S_PUSH pushes
// and S_OUT posts. One beat in flight; the output register frees the input side.
// Synchronous active-low reset restores register defaults and clears occupancy,
// ring pointers and LFSR (to seed 1); ring contents are not cleared. Uses rvref_pkg.
`timescale 1ns / 1ps

module random_victim_recent_evict_filter_unit #(
    parameter int HISTORY_DEPTH = rvref_pkg::HISTORY_DEPTH_DEF,
    parameter int SLOT_BITS     = rvref_pkg::SLOT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rvref_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rvref_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rvref_pkg::TAG_W-1:0]      i_request_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_evict_needed,
    output logic [SLOT_BITS-1:0]             o_victim_slot,
    output logic [rvref_pkg::RETRY_W-1:0]    o_retries_taken,
    output logic                             o_forced_repeat,
    output logic [rvref_pkg::TAG_W-1:0]      o_tag_echo
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
    localparam int OCC_W = SLOT_BITS + 1;
    localparam logic [63:0] SLOT_CAP = 64'd1 << SLOT_BITS;

    rvref_pkg::t_state r_state, n_state;

    logic [rvref_pkg::TOTAL_SLOTS_W-1:0] r_total_slots, n_total_slots;
    logic [rvref_pkg::HIST_LEN_W-1:0]    r_history_len, n_history_len;
    logic [rvref_pkg::MAX_RETRY_W-1:0]   r_retry_limit, n_retry_limit;
    logic [rvref_pkg::LFSR_W-1:0]        r_lfsr, n_lfsr;
    logic [OCC_W-1:0]                    r_occ, n_occ;
    logic [PTR_W-1:0]                    r_head, n_head;
    logic [PTR_W-1:0]                    r_tail, n_tail;
    logic [PTR_W-1:0]                    r_rd_ptr, n_rd_ptr;
    logic                                r_cmp_vld, n_cmp_vld;

    logic [rvref_pkg::TAG_W-1:0]   r_tag, n_tag;
    logic [SLOT_BITS-1:0]          r_pick, n_pick;
    logic [rvref_pkg::RETRY_W-1:0] r_retries, n_retries;
    logic                          r_hit, n_hit;
    logic                          r_evict, n_evict;

    logic                          r_out_vld, n_out_vld;
    logic                          r_o_evict, n_o_evict;
    logic [SLOT_BITS-1:0]          r_o_slot, n_o_slot;
    logic [rvref_pkg::RETRY_W-1:0] r_o_retries, n_o_retries;
    logic                          r_o_hit, n_o_hit;
    logic [rvref_pkg::TAG_W-1:0]   r_o_tag, n_o_tag;

    logic [OCC_W-1:0]             w_limit;
    logic [LEN_W-1:0]             w_len;
    logic [rvref_pkg::LFSR_W-1:0] w_lfsr_nx;
    logic                         w_div_start;
    logic                         w_div_done;
    logic [SLOT_BITS-1:0]         w_div_rem;
    logic                         w_we;
    logic [SLOT_BITS-1:0]         w_rdata;
    logic                         w_issue;
    logic                         w_match;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                  input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] s;
        s = LEN_W'(p) + LEN_W'(1);
        return (s == len) ? '0 : PTR_W'(s);
    endfunction

    always_comb begin
        if (r_total_slots < rvref_pkg::TOTAL_SLOTS_W'(2)) begin
            w_limit = OCC_W'(2);
        end else if (64'(r_total_slots) > SLOT_CAP) begin
            w_limit = OCC_W'(SLOT_CAP);
        end else begin
            w_limit = OCC_W'(r_total_slots);
        end
        if (r_history_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_history_len) > 32'(HISTORY_DEPTH)) begin
            w_len = LEN_W'(HISTORY_DEPTH);
        end else begin
            w_len = LEN_W'(r_history_len);
        end
    end

    assign w_lfsr_nx = rvref_pkg::lfsr_next(r_lfsr);
    assign w_issue   = (r_rd_ptr != r_tail);
    assign w_match   = r_cmp_vld && (w_rdata == r_pick);

    rvref_mod_unit #(
        .SLOT_BITS (SLOT_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_lfsr_nx),
        .i_divisor  (r_occ),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    rvref_ring_mem #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (SLOT_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (r_pick),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_total_slots = r_total_slots;
        n_history_len = r_history_len;
        n_retry_limit = r_retry_limit;
        n_lfsr        = r_lfsr;
        n_occ         = r_occ;
        n_head        = r_head;
        n_tail        = r_tail;
        n_rd_ptr      = r_rd_ptr;
        n_cmp_vld     = r_cmp_vld;
        n_tag         = r_tag;
        n_pick        = r_pick;
        n_retries     = r_retries;
        n_hit         = r_hit;
        n_evict       = r_evict;
        n_out_vld     = r_out_vld;
        n_o_evict     = r_o_evict;
        n_o_slot      = r_o_slot;
        n_o_retries   = r_o_retries;
        n_o_hit       = r_o_hit;
        n_o_tag       = r_o_tag;
        w_div_start   = 1'b0;
        w_we          = 1'b0;

        if (i_cfg_valid) begin
            case (rvref_pkg::t_cfg_idx'(i_cfg_index))
                rvref_pkg::CFG_TOTAL_SLOTS: begin
                    n_total_slots = i_cfg_data[rvref_pkg::TOTAL_SLOTS_W-1:0];
                end
                rvref_pkg::CFG_HISTORY_LEN: begin
                    n_history_len = i_cfg_data[rvref_pkg::HIST_LEN_W-1:0];
                    n_head        = '0;
                    n_tail        = '0;
                end
                rvref_pkg::CFG_RETRY_LIMIT: begin
                    n_retry_limit = i_cfg_data[rvref_pkg::MAX_RETRY_W-1:0];
                end
                rvref_pkg::CFG_LFSR_SEED: begin
                    n_lfsr = (i_cfg_data == '0) ? rvref_pkg::LFSR_SEED_RST
                                                : i_cfg_data[rvref_pkg::LFSR_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            rvref_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_tag     = i_request_tag;
                    n_retries = '0;
                    if (r_occ < w_limit) begin
                        n_occ   = r_occ + OCC_W'(1);
                        n_evict = 1'b0;
                        n_pick  = '0;
                        n_hit   = 1'b0;
                        n_state = rvref_pkg::S_OUT;
                    end else begin
                        n_lfsr      = w_lfsr_nx;
                        w_div_start = 1'b1;
                        n_state     = rvref_pkg::S_DIV;
                    end
                end
            end
            rvref_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_pick    = w_div_rem;
                    n_rd_ptr  = r_head;
                    n_cmp_vld = 1'b0;
                    n_state   = rvref_pkg::S_SRCH;
                end
            end
            rvref_pkg::S_SRCH: begin
                if (w_match) begin
                    n_retries = r_retries + rvref_pkg::RETRY_W'(1);
                    if (r_retries == rvref_pkg::RETRY_W'(r_retry_limit)) begin
                        n_hit   = 1'b1;
                        n_state = rvref_pkg::S_PUSH;
                    end else begin
                        n_lfsr      = w_lfsr_nx;
                        w_div_start = 1'b1;
                        n_state     = rvref_pkg::S_DIV;
                    end
                end else if (!w_issue) begin
                    n_hit   = 1'b0;
                    n_state = rvref_pkg::S_PUSH;
                end else begin
                    n_rd_ptr  = ptr_inc(r_rd_ptr, w_len);
                    n_cmp_vld = 1'b1;
                end
            end
            rvref_pkg::S_PUSH: begin
                w_we    = 1'b1;
                n_tail  = ptr_inc(r_tail, w_len);
                if (ptr_inc(r_tail, w_len) == r_head) begin
                    n_head = ptr_inc(r_head, w_len);
                end
                n_evict = 1'b1;
                n_state = rvref_pkg::S_OUT;
            end
            rvref_pkg::S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld   = 1'b1;
                    n_o_evict   = r_evict;
                    n_o_slot    = r_pick;
                    n_o_retries = r_retries;
                    n_o_hit     = r_hit;
                    n_o_tag     = r_tag;
                    n_state     = rvref_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rvref_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rvref_pkg::S_IDLE;
            r_total_slots <= rvref_pkg::TOTAL_SLOTS_RST;
            r_history_len <= rvref_pkg::HIST_LEN_RST;
            r_retry_limit <= rvref_pkg::MAX_RETRY_RST;
            r_lfsr        <= rvref_pkg::LFSR_SEED_RST;
            r_occ         <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_rd_ptr      <= '0;
            r_cmp_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_total_slots <= n_total_slots;
            r_history_len <= n_history_len;
            r_retry_limit <= n_retry_limit;
            r_lfsr        <= n_lfsr;
            r_occ         <= n_occ;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_rd_ptr      <= n_rd_ptr;
            r_cmp_vld     <= n_cmp_vld;
            r_out_vld     <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_pick      <= n_pick;
        r_retries   <= n_retries;
        r_hit       <= n_hit;
        r_evict     <= n_evict;
        r_o_evict   <= n_o_evict;
        r_o_slot    <= n_o_slot;
        r_o_retries <= n_o_retries;
        r_o_hit     <= n_o_hit;
        r_o_tag     <= n_o_tag;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_stall      = (r_state != rvref_pkg::S_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_evict_needed  = r_o_evict;
    assign o_victim_slot   = r_o_slot;
    assign o_retries_taken = r_o_retries;
    assign o_forced_repeat = r_o_hit;
    assign o_tag_echo      = r_o_tag;

endmodule

// File: tb/evict_choice_checker.sv
// Scoreboard for the random victim selector: follows register writes, predicts
// each eviction choice on input beats and compares output beats field by field.
// Depends on rvref_pkg for widths, register codes and the LFSR taps.
`timescale 1ns / 1ps

module evict_choice_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  rvref_pkg::t_cfg_idx              i_cfg_index,
    input  logic [rvref_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [rvref_pkg::TAG_W-1:0]      i_request_tag,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_evict_needed,
    input  logic [rvref_pkg::SLOT_BITS_DEF-1:0] i_victim_slot,
    input  logic [rvref_pkg::RETRY_W-1:0]    i_retries_taken,
    input  logic                             i_forced_repeat,
    input  logic [rvref_pkg::TAG_W-1:0]      i_tag_echo,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_results,
    output int                               o_evictions,
    output int                               o_forced,
    output int                               o_deepest
);
    import rvref_pkg::*;

    localparam int unsigned SLOT_CAP = 1 << SLOT_BITS_DEF;

    typedef struct packed {
        logic                     evict;
        logic [SLOT_BITS_DEF-1:0] slot;
        logic [RETRY_W-1:0]       retries;
        logic                     forced;
        logic [TAG_W-1:0]         tag;
    } eviction_t;

    eviction_t predicted_choices[$];

    logic [TOTAL_SLOTS_W-1:0] slots_cfg;
    logic [HIST_LEN_W-1:0]    hist_cfg;
    logic [MAX_RETRY_W-1:0]   retry_cfg;
    logic [LFSR_W-1:0]        lfsr;
    int unsigned              occupancy;
    logic [SLOT_BITS_DEF-1:0] recent_slots [HISTORY_DEPTH_DEF];
    int unsigned              ring_head;
    int unsigned              ring_tail;

    int mismatches = 0;
    int results_seen = 0;
    int evictions_seen = 0;
    int forced_seen = 0;
    int deepest_search = 0;

    assign o_errors    = mismatches;
    assign o_results   = results_seen;
    assign o_evictions = evictions_seen;
    assign o_forced    = forced_seen;
    assign o_deepest   = deepest_search;

    function automatic int unsigned slot_limit();
        if (slots_cfg < 2) return 2;
        if (slots_cfg > SLOT_CAP) return SLOT_CAP;
        return slots_cfg;
    endfunction

    function automatic int unsigned history_span();
        if (hist_cfg < 1) return 1;
        if (hist_cfg > HISTORY_DEPTH_DEF) return HISTORY_DEPTH_DEF;
        return hist_cfg;
    endfunction

    function automatic logic [LFSR_W-1:0] advance_lfsr(input logic [LFSR_W-1:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

    function automatic bit recently_evicted(input logic [SLOT_BITS_DEF-1:0] slot,
                                            input int unsigned span);
        int unsigned idx;
        int unsigned n;
        idx = ring_head;
        for (n = 0; n < span && idx != ring_tail; n++) begin
            if (recent_slots[idx] == slot) return 1'b1;
            idx = (idx + 1) % span;
        end
        return 1'b0;
    endfunction

    function automatic eviction_t choose_victim(input logic [TAG_W-1:0] tag);
        eviction_t   r;
        int unsigned span;
        int unsigned tries;
        int unsigned pick;
        bit          hit;
        r = '0;
        r.tag = tag;
        if (occupancy < slot_limit()) begin
            occupancy++;
            return r;
        end
        span  = history_span();
        tries = 0;
        pick  = 0;
        hit   = 1'b1;
        while (hit && tries <= retry_cfg) begin
            lfsr = advance_lfsr(lfsr);
            pick = lfsr % occupancy;
            hit  = recently_evicted(pick[SLOT_BITS_DEF-1:0], span);
            if (hit) tries++;
        end
        recent_slots[ring_tail] = pick[SLOT_BITS_DEF-1:0];
        ring_tail = (ring_tail + 1) % span;
        if (ring_tail == ring_head) ring_head = (ring_head + 1) % span;
        r.evict   = 1'b1;
        r.slot    = pick[SLOT_BITS_DEF-1:0];
        r.retries = tries[RETRY_W-1:0];
        r.forced  = hit;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : track
        eviction_t want;
        if (!i_rst_n) begin
            slots_cfg = TOTAL_SLOTS_RST;
            hist_cfg  = HIST_LEN_RST;
            retry_cfg = MAX_RETRY_RST;
            lfsr      = LFSR_SEED_RST;
            occupancy = 0;
            ring_head = 0;
            ring_tail = 0;
            predicted_choices.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_choices.size() == 0) begin
                    report_mismatch("unexpected beat, tag_echo", i_tag_echo, '0);
                end else begin
                    want = predicted_choices.pop_front();
                    if (i_evict_needed !== want.evict)
                        report_mismatch("evict_needed", i_evict_needed, want.evict);
                    if (i_victim_slot !== want.slot)
                        report_mismatch("victim_slot", i_victim_slot, want.slot);
                    if (i_retries_taken !== want.retries)
                        report_mismatch("retries_taken", i_retries_taken, want.retries);
                    if (i_forced_repeat !== want.forced)
                        report_mismatch("forced_repeat", i_forced_repeat, want.forced);
                    if (i_tag_echo !== want.tag)
                        report_mismatch("tag_echo", i_tag_echo, want.tag);
                    results_seen++;
                    if (want.evict) evictions_seen++;
                    if (want.forced) forced_seen++;
                    if (want.retries > deepest_search) deepest_search = want.retries;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOTAL_SLOTS: slots_cfg = i_cfg_data[TOTAL_SLOTS_W-1:0];
                    CFG_HISTORY_LEN: begin
                        hist_cfg  = i_cfg_data[HIST_LEN_W-1:0];
                        ring_head = 0;
                        ring_tail = 0;
                    end
                    CFG_RETRY_LIMIT: retry_cfg = i_cfg_data[MAX_RETRY_W-1:0];
                    CFG_LFSR_SEED: lfsr = (i_cfg_data != '0) ? i_cfg_data : LFSR_W'(1);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predicted_choices.push_back(choose_victim(i_request_tag));
        end
        o_pending <= predicted_choices.size();
    end

endmodule

// File: tb/tb_random_victim_recent_evict_filter_unit.sv
// Top of the victim selector testbench: clock, reset, register setup, request
// stimulus with idle and stall patterns, watchdog and verdict.
// Depends on rvref_pkg, the block and evict_choice_checker.
`timescale 1ns / 1ps

module tb_random_victim_recent_evict_filter_unit;
    import rvref_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PHASES  = 8;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    t_cfg_idx                 cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [TAG_W-1:0]         request_tag;
    logic                     out_valid;
    logic                     out_stall;
    logic                     evict_needed;
    logic [SLOT_BITS_DEF-1:0] victim_slot;
    logic [RETRY_W-1:0]       retries_taken;
    logic                     forced_repeat;
    logic [TAG_W-1:0]         tag_echo;

    int errors;
    int pending;
    int results;
    int evictions;
    int forced;
    int deepest;

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int items_sent = 0;
    int writes_done = 0;
    int settings_done = 0;

    random_victim_recent_evict_filter_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_request_tag  (request_tag),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_evict_needed (evict_needed),
        .o_victim_slot  (victim_slot),
        .o_retries_taken(retries_taken),
        .o_forced_repeat(forced_repeat),
        .o_tag_echo     (tag_echo)
    );

    evict_choice_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_request_tag  (request_tag),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_evict_needed (evict_needed),
        .i_victim_slot  (victim_slot),
        .i_retries_taken(retries_taken),
        .i_forced_repeat(forced_repeat),
        .i_tag_echo     (tag_echo),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results),
        .o_evictions    (evictions),
        .o_forced       (forced),
        .o_deepest      (deepest)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin : receiver
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_random_victim_recent_evict_filter_unit: done, errors");
        $finish;
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 57; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 57; end
            default:       begin send_idle_pct = 20; stall_pct = 20; end
        endcase
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        writes_done++;
    endtask

    task automatic set_config(input logic [31:0] slots, input logic [31:0] hist,
                              input logic [31:0] retries, input logic [31:0] seed);
        write_reg(CFG_TOTAL_SLOTS, slots);
        write_reg(CFG_HISTORY_LEN, hist);
        write_reg(CFG_RETRY_LIMIT, retries);
        write_reg(CFG_LFSR_SEED, seed);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic send_tag(input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        request_tag <= tag;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_burst(input int count);
        int n;
        for (n = 0; n < count; n++) send_tag(TAG_W'($urandom_range(255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int p;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_TOTAL_SLOTS;
        cfg_data    = '0;
        in_valid    = 1'b0;
        request_tag = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(IDLE_NONE);

        // two slots, saturated history, no retries, zero seed: fill then evictions
        set_config(32'd0, 32'd63, 32'd0, 32'd0);
        send_tag(8'h00);
        send_tag(8'hFF);
        send_tag(8'h55);
        send_tag(8'hAA);
        send_tag(8'h0F);
        send_tag(8'hF0);
        drain();

        // every pick recent once the ring covers both slots: full retry budget
        set_config(32'd1, 32'd32, 32'd255, 32'hFFFF_FFFF);
        send_burst(4);
        drain();

        // no history kept
        set_config(32'd8, 32'd0, 32'd3, 32'h8000_0000);
        send_burst(9);
        drain();

        // slot count below occupancy
        set_config(32'd2, 32'd2, 32'd7, $urandom);
        send_burst(4);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            set_idle(idle_mode_t'(p % 4));
            set_config($urandom_range(48 * (p + 1), 2), $urandom_range(63),
                       $urandom_range(7), $urandom);
            if (p == 4) hold_req = 1'b1;
            send_burst(90);
            drain();
        end

        // slot count above the cap: saturated limit, fill beats only
        set_idle(IDLE_NONE);
        set_config(32'hFFFF_FFFF, 32'd32, 32'd255, $urandom);
        send_burst(20);
        drain();

        repeat (40) @(posedge clk);
        $display("%0d request beats, %0d results checked: %0d evictions, %0d forced repeats",
                 items_sent, results, evictions, forced);
        $display("%0d register writes over %0d settings, deepest search %0d retries",
                 writes_done, settings_done, deepest);
        if (errors == 0 && pending == 0)
            $display("tb_random_victim_recent_evict_filter_unit: done, clean");
        else
            $display("tb_random_victim_recent_evict_filter_unit: done, errors");
        $finish;
    end

endmodule
